/* rtl/core/sorted_deadline_timer_queue_top_assert.svh */
// assertion macros for the sorted deadline timer queue checker
`ifndef SORTED_DEADLINE_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SDTQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdtq assertion failed");

// next-cycle implication, disabled in reset
`define SDTQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdtq assertion failed");

// next-cycle implication, active through reset
`define SDTQ_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sdtq assertion failed");

`endif

/* rtl/core/sdtq_pkg.sv */
// shared constants and types of the sorted deadline timer queue
package sdtq_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_BITS = $clog2(SLOT_COUNT);
    localparam int SLOT_FIELD_BITS = 4;
    localparam int TIME_BITS = 48;
    localparam int RESULT_CAP = 16;
    localparam int CAP_BITS = $clog2(RESULT_CAP + 1);
    localparam int ORDER_BITS = 32;
    localparam int TAG_BITS = 32;
    localparam int DELAY_BITS = 32;
    localparam int CMD_BITS = 2;
    localparam int KIND_BITS = 3;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd2;

    localparam logic [KIND_BITS-1:0] KIND_INSERTED    = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_FULL        = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_CANCELLED   = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_CANCEL_FREE = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_EXPIRED     = 3'd4;

    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_STALE  = 2'd2;

    typedef struct packed {
        logic [CMD_BITS-1:0]        op;
        logic [DELAY_BITS-1:0]      delay;
        logic [TAG_BITS-1:0]        tag;
        logic [SLOT_FIELD_BITS-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

    typedef struct packed {
        logic [KIND_BITS-1:0]       kind;
        logic [SLOT_FIELD_BITS-1:0] slot;
        logic [TAG_BITS-1:0]        tag;
        logic                       last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_res_push;

endpackage

/* rtl/core/sdtq_front.sv */
// command front end: accepts transactions, drops unknown commands, queues the rest
module sdtq_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [sdtq_pkg::CMD_BITS-1:0]        i_cmd,
    input  logic [sdtq_pkg::DELAY_BITS-1:0]      i_delay_ticks,
    input  logic [sdtq_pkg::TAG_BITS-1:0]        i_tag,
    input  logic [sdtq_pkg::SLOT_FIELD_BITS-1:0] i_slot,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic                                 i_pop,
    output sdtq_pkg::t_cmd_q                     o_q
);

    sdtq_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           w_known;
    logic           w_wr;
    logic           w_rd;

    always_comb begin
        unique case (i_cmd) inside
            sdtq_pkg::CMD_INSERT, sdtq_pkg::CMD_CANCEL, sdtq_pkg::CMD_TICK: w_known = 1'b1;
            default: w_known = 1'b0;
        endcase
    end

    assign o_full      = (r_count == 2'd2);
    assign w_wr        = i_push && !o_full && w_known;
    assign w_rd        = i_pop && (r_count != 2'd0);
    assign o_q.valid   = (r_count != 2'd0);
    assign o_q.cmd     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= '{op: i_cmd, delay: i_delay_ticks, tag: i_tag, slot: i_slot};
        end
    end

endmodule

/* rtl/core/sdtq_engine.sv */
// timer engine: slot pool, insert and cancel, deadline scan with one comparator
module sdtq_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdtq_pkg::t_cmd_q    i_cmd_q,
    output logic                o_cmd_pop,
    output sdtq_pkg::t_res_push o_res,
    input  logic                i_res_full
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    localparam int SB = sdtq_pkg::SLOT_BITS;
    localparam int TB = sdtq_pkg::TIME_BITS;
    localparam int FB = sdtq_pkg::SLOT_FIELD_BITS;
    localparam int CB = sdtq_pkg::CAP_BITS;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [1:0]                      r_status   [sdtq_pkg::SLOT_COUNT];
    logic [TB-1:0]                   r_deadline [sdtq_pkg::SLOT_COUNT];
    logic [sdtq_pkg::TAG_BITS-1:0]   r_tag_mem  [sdtq_pkg::SLOT_COUNT];
    logic [sdtq_pkg::ORDER_BITS-1:0] r_order    [sdtq_pkg::SLOT_COUNT];
    logic [TB-1:0]                   r_time;
    logic [sdtq_pkg::ORDER_BITS-1:0] r_counter;
    logic [SB-1:0]                   r_idx;
    logic                            r_found;
    logic [SB-1:0]                   r_best_idx;
    logic [TB-1:0]                   r_best_dl;
    logic [sdtq_pkg::ORDER_BITS-1:0] r_best_order;
    logic [sdtq_pkg::TAG_BITS-1:0]   r_best_tag;
    logic                            r_pend_valid;
    logic [SB-1:0]                   r_pend_slot;
    logic [sdtq_pkg::TAG_BITS-1:0]   r_pend_tag;
    logic [CB-1:0]                   r_n;

    logic                            w_has_free;
    logic [SB-1:0]                   w_free_idx;
    logic                            w_cand;
    logic                            w_better;
    logic [TB:0]                     w_sum;
    logic [TB-1:0]                   w_new_dl;
    logic [SB-1:0]                   w_cancel_idx;
    logic                            w_do_insert;
    logic                            w_do_cancel;
    logic                            w_do_tick;
    logic                            w_take;
    logic                            w_last_idx;

    always_comb begin
        w_has_free = 1'b0;
        w_free_idx = '0;
        for (int i = sdtq_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_status[i] == sdtq_pkg::ST_FREE) begin
                w_has_free = 1'b1;
                w_free_idx = SB'(i);
            end
        end
    end

    assign w_sum        = {1'b0, r_time} + (TB + 1)'(i_cmd_q.cmd.delay);
    assign w_new_dl     = (w_sum > {1'b0, sdtq_pkg::TIME_MAX}) ? sdtq_pkg::TIME_MAX
                                                               : w_sum[TB-1:0];
    assign w_cancel_idx = i_cmd_q.cmd.slot[SB-1:0];
    assign w_last_idx   = (r_idx == SB'(sdtq_pkg::SLOT_COUNT - 1));

    assign w_cand   = (r_status[r_idx] == sdtq_pkg::ST_ACTIVE) && (r_deadline[r_idx] <= r_time);
    assign w_better = w_cand && (!r_found || (r_deadline[r_idx] < r_best_dl) ||
                      ((r_deadline[r_idx] == r_best_dl) && (r_order[r_idx] > r_best_order)));

    assign w_do_insert = o_cmd_pop && (i_cmd_q.cmd.op == sdtq_pkg::CMD_INSERT) && w_has_free;
    assign w_do_cancel = o_cmd_pop && (i_cmd_q.cmd.op == sdtq_pkg::CMD_CANCEL);
    assign w_do_tick   = o_cmd_pop && (i_cmd_q.cmd.op == sdtq_pkg::CMD_TICK);
    assign w_take      = (r_state == S_DECIDE) && !i_res_full && r_found;

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_q.valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd_q.cmd.op)
                        sdtq_pkg::CMD_INSERT: begin
                            o_res.valid = 1'b1;
                            o_res.data.last = 1'b1;
                            if (w_has_free) begin
                                o_res.data.kind = sdtq_pkg::KIND_INSERTED;
                                o_res.data.slot = FB'(w_free_idx);
                                o_res.data.tag  = i_cmd_q.cmd.tag;
                            end else begin
                                o_res.data.kind = sdtq_pkg::KIND_FULL;
                            end
                        end
                        sdtq_pkg::CMD_CANCEL: begin
                            o_res.valid = 1'b1;
                            o_res.data.last = 1'b1;
                            o_res.data.slot = i_cmd_q.cmd.slot;
                            o_res.data.kind = (r_status[w_cancel_idx] != sdtq_pkg::ST_FREE)
                                              ? sdtq_pkg::KIND_CANCELLED
                                              : sdtq_pkg::KIND_CANCEL_FREE;
                        end
                        sdtq_pkg::CMD_TICK: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_last_idx) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_res_full) begin
                    if (r_found) begin
                        o_res.valid     = r_pend_valid;
                        o_res.data.kind = sdtq_pkg::KIND_EXPIRED;
                        o_res.data.slot = FB'(r_pend_slot);
                        o_res.data.tag  = r_pend_tag;
                        n_state = ((r_n + 1'b1) == CB'(sdtq_pkg::RESULT_CAP)) ? S_FLUSH : S_SCAN;
                    end else begin
                        n_state = r_pend_valid ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_res_full) begin
                    o_res.valid     = 1'b1;
                    o_res.data.kind = sdtq_pkg::KIND_EXPIRED;
                    o_res.data.slot = FB'(r_pend_slot);
                    o_res.data.tag  = r_pend_tag;
                    o_res.data.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_time       <= '0;
            r_counter    <= '0;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_n          <= '0;
            for (int i = 0; i < sdtq_pkg::SLOT_COUNT; i++) begin
                r_status[i] <= sdtq_pkg::ST_FREE;
            end
        end else begin
            r_state <= n_state;
            if (w_do_insert) begin
                r_status[w_free_idx] <= sdtq_pkg::ST_ACTIVE;
                r_counter <= r_counter + 1'b1;
            end
            if (w_do_cancel) begin
                r_status[w_cancel_idx] <= sdtq_pkg::ST_FREE;
            end
            if (w_do_tick) begin
                if (r_time != sdtq_pkg::TIME_MAX) begin
                    r_time <= r_time + 1'b1;
                end
                r_idx        <= '0;
                r_found      <= 1'b0;
                r_pend_valid <= 1'b0;
                r_n          <= '0;
            end
            if (r_state == S_SCAN) begin
                if (w_better) begin
                    r_found <= 1'b1;
                end
                r_idx <= w_last_idx ? '0 : r_idx + 1'b1;
            end
            if (w_take) begin
                r_status[r_best_idx] <= sdtq_pkg::ST_STALE;
                r_pend_valid <= 1'b1;
                r_found      <= 1'b0;
                r_n          <= r_n + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_insert) begin
            r_deadline[w_free_idx] <= w_new_dl;
            r_tag_mem[w_free_idx]  <= i_cmd_q.cmd.tag;
            r_order[w_free_idx]    <= r_counter;
        end
        if ((r_state == S_SCAN) && w_better) begin
            r_best_idx   <= r_idx;
            r_best_dl    <= r_deadline[r_idx];
            r_best_order <= r_order[r_idx];
            r_best_tag   <= r_tag_mem[r_idx];
        end
        if (w_take) begin
            r_pend_slot <= r_best_idx;
            r_pend_tag  <= r_best_tag;
        end
    end

endmodule

/* rtl/core/sdtq_out_fifo.sv */
// result queue between the timer engine and the result port
module sdtq_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdtq_pkg::t_res_push i_push,
    output logic                o_full,
    output logic                o_empty,
    output sdtq_pkg::t_result   o_data,
    input  logic                i_pop
);

    localparam int DEPTH = 4;
    localparam int PB = $clog2(DEPTH);

    sdtq_pkg::t_result r_mem [DEPTH];
    logic [PB-1:0]     r_wr_ptr;
    logic [PB-1:0]     r_rd_ptr;
    logic [PB:0]       r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_count == (PB + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PB + 1)'(w_wr) - (PB + 1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

endmodule

/* rtl/core/sorted_deadline_timer_queue_top.sv */
// sorted deadline timer queue: command queue, timer engine and result queue
// insert, cancel: result via both queues; one per cycle while idle, result queue not full
// tick: a scan pass over all slots per expired entry, then a final empty pass unless
// RESULT_CAP expire; at most RESULT_CAP passes, then the last result; nothing if none due
// the single deadline comparator in the scan loop sets the tick rate
// synchronous active-low reset frees all slots, clears time, counter and both queues
module sorted_deadline_timer_queue_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [sdtq_pkg::CMD_BITS-1:0]        i_cmd,
    input  logic [sdtq_pkg::DELAY_BITS-1:0]      i_delay_ticks,
    input  logic [sdtq_pkg::TAG_BITS-1:0]        i_tag,
    input  logic [sdtq_pkg::SLOT_FIELD_BITS-1:0] i_slot,
    input  logic                                 push,
    output logic                                 full,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [sdtq_pkg::KIND_BITS-1:0]       o_kind,
    output logic [sdtq_pkg::SLOT_FIELD_BITS-1:0] o_out_slot,
    output logic [sdtq_pkg::TAG_BITS-1:0]        o_out_tag,
    output logic                                 o_last
);

    sdtq_pkg::t_cmd_q    w_cmd_q;
    logic                w_cmd_pop;
    sdtq_pkg::t_res_push w_res;
    logic                w_res_full;
    sdtq_pkg::t_result   w_head;

    sdtq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_delay_ticks (i_delay_ticks),
        .i_tag         (i_tag),
        .i_slot        (i_slot),
        .i_push        (push),
        .o_full        (full),
        .i_pop         (w_cmd_pop),
        .o_q           (w_cmd_q)
    );

    sdtq_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_q    (w_cmd_q),
        .o_cmd_pop  (w_cmd_pop),
        .o_res      (w_res),
        .i_res_full (w_res_full)
    );

    sdtq_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_data  (w_head),
        .i_pop   (pop)
    );

    assign o_kind     = w_head.kind;
    assign o_out_slot = w_head.slot;
    assign o_out_tag  = w_head.tag;
    assign o_last     = w_head.last;

endmodule

/* rtl/core/sdtq_checker.sv */
// port-level checker for the sorted deadline timer queue, bound to the top level
`include "sorted_deadline_timer_queue_top_assert.svh"

module sdtq_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 full,
    input logic                                 empty,
    input logic                                 pop,
    input logic [sdtq_pkg::KIND_BITS-1:0]       o_kind,
    input logic [sdtq_pkg::SLOT_FIELD_BITS-1:0] o_out_slot,
    input logic [sdtq_pkg::TAG_BITS-1:0]        o_out_tag,
    input logic                                 o_last
);

    `SDTQ_ASSERT_RST(a_reset_clears, !i_rst_n, empty && !full)
    `SDTQ_ASSERT_IMP(a_kind_range, !empty, o_kind <= sdtq_pkg::KIND_EXPIRED)
    `SDTQ_ASSERT_IMP(a_single_last, !empty && (o_kind != sdtq_pkg::KIND_EXPIRED), o_last)
    `SDTQ_ASSERT_IMP(a_full_zero, !empty && (o_kind == sdtq_pkg::KIND_FULL), (o_out_slot == '0) && (o_out_tag == '0))
    `SDTQ_ASSERT_NXT(a_head_holds, !empty && !pop, !empty && $stable(o_kind) && $stable(o_out_tag))

endmodule

bind sorted_deadline_timer_queue_top sdtq_checker u_checker (.*);
